>>> rtl/core/hmi_pkg.sv
// Package with the shared types and constants of the hyperbolic moveout index block.
`timescale 1ns / 1ps

package hmi_pkg;

    // Configuration register indexes and reset values.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SAMPLE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_IN_USE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURVES_IN_USE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_MODE    = 3'd4;

    localparam logic [31:0] SAMPLE_INTERVAL_RESET = 32'd67109;
    localparam logic [11:0] START_SAMPLE_RESET    = 12'd0;
    localparam logic [12:0] SAMPLES_IN_USE_RESET  = 13'd4096;
    localparam logic [8:0]  CURVES_IN_USE_RESET   = 9'd256;

    // Arithmetic widths.
    localparam int DIV_W      = 106;          // dividend h^2 * 2^42
    localparam int DIV_STAGES = DIV_W / 2;    // two quotient bits per stage
    localparam int SEL_W      = 122;          // selected h^2 term, Q.48
    localparam int X_W        = 124;          // four times the squared time
    localparam int ROOT_W     = X_W / 2;      // one root bit per stage
    localparam int Q_W        = 14;           // root / dt, saturating
    localparam int Q_STAGES   = Q_W / 2;      // two quotient bits per stage

    typedef struct packed {
        logic [11:0] sample_index;
        logic [7:0]  offset_index;
        logic [7:0]  curve_index;
        logic [31:0] time_value;
        logic [31:0] offset_value;
        logic [31:0] velocity_term;
    } point_t;

    typedef struct packed {
        logic [11:0] sample;
        logic [29:0] off_nqnt;
        logic [20:0] curve_nt;
        logic [20:0] off_nt;
        logic [63:0] h2;
        logic [63:0] tv2;
        logic [31:0] vt;
        logic        pre_ok;
        logic        fault;
    } p1_t;

    typedef struct packed {
        logic [27:0] entry_slot;
        logic [19:0] model_address;
        logic [19:0] data_base;
        logic        pre_ok;
        logic        divide_fault;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [DIV_W-1:0] nq;
        logic [31:0]      rem;
        logic [63:0]      h2;
        logic [63:0]      tv2;
        logic [31:0]      vt;
    } div_t;

    typedef struct packed {
        tag_t             tag;
        logic [DIV_W-1:0] quot;
        logic [63:0]      tv2;
        logic [63:0]      pl;
        logic [63:0]      ph;
    } m1_t;

    typedef struct packed {
        tag_t             tag;
        logic [SEL_W-1:0] sel;
        logic [63:0]      tv2;
    } m2_t;

    typedef struct packed {
        tag_t              tag;
        logic [X_W-1:0]    x;
        logic [ROOT_W-1:0] root;
        logic [ROOT_W+2:0] rem;
    } sq_t;

    typedef struct packed {
        tag_t           tag;
        logic [Q_W-1:0] q;
        logic [31:0]    rem;
        logic [Q_W-1:0] s_lo;
        logic           ovf;
    } qd_t;

    typedef struct packed {
        logic [27:0] entry_slot;
        logic [19:0] data_address;
        logic [19:0] model_address;
        logic        pair_valid;
        logic        divide_fault;
    } pair_t;

endpackage

>>> rtl/core/hmi_point_if.sv
// Stream interface that carries one grid point per transaction.
`timescale 1ns / 1ps

interface hmi_point_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample_index;
    logic [7:0]  offset_index;
    logic [7:0]  curve_index;
    logic [31:0] time_value;
    logic [31:0] offset_value;
    logic [31:0] velocity_term;

    modport source (
        output valid, sample_index, offset_index, curve_index,
               time_value, offset_value, velocity_term,
        input  ready
    );
    modport sink (
        input  valid, sample_index, offset_index, curve_index,
               time_value, offset_value, velocity_term,
        output ready
    );
endinterface

>>> rtl/core/hmi_pair_if.sv
// Stream interface that carries one index pair per transaction.
`timescale 1ns / 1ps

interface hmi_pair_if;
    logic        valid;
    logic        ready;
    logic [27:0] entry_slot;
    logic [19:0] data_address;
    logic [19:0] model_address;
    logic        pair_valid;
    logic        divide_fault;

    modport source (
        output valid, entry_slot, data_address, model_address,
               pair_valid, divide_fault,
        input  ready
    );
    modport sink (
        input  valid, entry_slot, data_address, model_address,
               pair_valid, divide_fault,
        output ready
    );
endinterface

>>> rtl/core/hyperbolic_moveout_index_top.sv
// Top level of the hyperbolic moveout index generator.
`timescale 1ns / 1ps

// Usage: grid points arrive on the points channel, one per transaction, and
// every point yields exactly one index pair on the pairs channel, in order.
// A transaction happens at a rising edge of clk where valid and ready are
// both high. Configuration goes through a plain write port (cfg_write,
// cfg_index, cfg_data) and must only be written while the pipeline is empty.
// Throughput: one point per cycle while the receiver does not stall,
// because every stage holds its own item. The depth is set by the
// restoring divider for h^2/v (53 stages of two bits), the digit-by-digit
// square root (62 stages of one bit) and the divide by the sample interval
// (7 stages of two bits). Reset (rst_n low, asynchronous) empties the
// pipeline and loads the register defaults. When the receiver stalls the
// whole pipeline holds in place; points keep flowing in as long as the
// output register is empty or is being taken in the same cycle, so no
// transaction is lost or repeated.
module hyperbolic_moveout_index_top
    import hmi_pkg::*;
#(
    parameter int SAMPLES_MAX = 4096,
    parameter int OFFSETS_MAX = 256,
    parameter int CURVES_MAX  = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    hmi_point_if.sink              points,
    hmi_pair_if.source             pairs
);

    localparam int PIPE_DEPTH = 7 + DIV_STAGES + ROOT_W + Q_STAGES;

    // Configuration registers.
    logic [31:0] sample_interval_reg;
    logic [11:0] start_sample_reg;
    logic [12:0] samples_in_use_reg;
    logic [8:0]  curves_in_use_reg;
    logic        inverse_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_interval_reg <= SAMPLE_INTERVAL_RESET;
            start_sample_reg    <= START_SAMPLE_RESET;
            samples_in_use_reg  <= SAMPLES_IN_USE_RESET;
            curves_in_use_reg   <= CURVES_IN_USE_RESET;
            inverse_mode_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data;
                CFG_START_SAMPLE:    start_sample_reg    <= cfg_data[11:0];
                CFG_SAMPLES_IN_USE:  samples_in_use_reg  <= cfg_data[12:0];
                CFG_CURVES_IN_USE:   curves_in_use_reg   <= cfg_data[8:0];
                CFG_INVERSE_MODE:    inverse_mode_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Effective trace sizes, clamped to what the design was built for.
    logic [12:0] nt;
    logic [8:0]  nq;
    logic [21:0] nqnt_reg;

    assign nt = (32'(samples_in_use_reg) > SAMPLES_MAX) ? 13'(SAMPLES_MAX)
                                                        : samples_in_use_reg;
    assign nq = (32'(curves_in_use_reg) > CURVES_MAX) ? 9'(CURVES_MAX)
                                                      : curves_in_use_reg;

    // The product of the trace sizes only changes with configuration, so it
    // is kept in a register of its own.
    always_ff @(posedge clk)
    begin
        nqnt_reg <= 22'(nq) * 22'(nt);
    end

    // Pipeline control: every stage moves when the output register is free
    // or is being emptied. Valid bits travel in a shift line of their own.
    logic                  adv;
    logic [PIPE_DEPTH-1:0] v_reg;

    assign adv           = !v_reg[PIPE_DEPTH-1] || pairs.ready;
    assign points.ready  = adv;
    assign pairs.valid   = v_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], points.valid};
        end
    end

    // Stage registers.
    point_t s0_reg;
    p1_t    p1_reg;
    p1_t    p1_next;
    div_t   d_init;
    div_t   d_src  [DIV_STAGES];
    div_t   d_next [DIV_STAGES];
    div_t   d_reg  [DIV_STAGES];
    m1_t    m1_reg;
    m1_t    m1_next;
    m2_t    m2_reg;
    m2_t    m2_next;
    sq_t    m3_reg;
    sq_t    m3_next;
    sq_t    sq_src  [ROOT_W];
    sq_t    sq_next [ROOT_W];
    sq_t    sq_reg  [ROOT_W];
    qd_t    qp_reg;
    qd_t    qp_next;
    qd_t    q_src  [Q_STAGES];
    qd_t    q_next [Q_STAGES];
    qd_t    q_reg  [Q_STAGES];
    pair_t  out_reg;
    pair_t  out_next;

    // First stage: squares of offset and time, index products and range checks.
    always_comb
    begin
        logic [31:0] hmag;
        logic        fault;
        hmag  = s0_reg.offset_value[31] ? (~s0_reg.offset_value + 32'd1)
                                        : s0_reg.offset_value;
        fault = !inverse_mode_reg && (s0_reg.velocity_term == 32'd0);
        p1_next.sample   = s0_reg.sample_index;
        p1_next.off_nqnt = 30'(s0_reg.offset_index) * 30'(nqnt_reg);
        p1_next.curve_nt = 21'(s0_reg.curve_index) * 21'(nt);
        p1_next.off_nt   = 21'(s0_reg.offset_index) * 21'(nt);
        p1_next.h2       = 64'(hmag) * 64'(hmag);
        p1_next.tv2      = 64'(s0_reg.time_value) * 64'(s0_reg.time_value);
        p1_next.vt       = s0_reg.velocity_term;
        p1_next.fault    = fault;
        p1_next.pre_ok   = !fault
                           && (s0_reg.sample_index >= start_sample_reg)
                           && (13'(s0_reg.sample_index) < nt)
                           && (9'(s0_reg.curve_index) < nq)
                           && (32'(s0_reg.offset_index) < OFFSETS_MAX);
    end

    // Index sums and the start of the divider h^2 * 2^42 / v.
    always_comb
    begin
        d_init.tag.entry_slot    = 28'(p1_reg.off_nqnt + 30'(p1_reg.curve_nt)
                                       + 30'(p1_reg.sample));
        d_init.tag.model_address = 20'(p1_reg.curve_nt + 21'(p1_reg.sample));
        d_init.tag.data_base     = 20'(p1_reg.off_nt);
        d_init.tag.pre_ok        = p1_reg.pre_ok;
        d_init.tag.divide_fault  = p1_reg.fault;
        d_init.nq                = {p1_reg.h2, 42'd0};
        d_init.rem               = 32'd0;
        d_init.h2                = p1_reg.h2;
        d_init.tv2               = p1_reg.tv2;
        d_init.vt                = p1_reg.vt;
    end

    // Restoring divider, two quotient bits per stage. The quotient bits
    // shift into the low end as the dividend bits leave the high end.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            assign d_src[k] = d_init;
        end
        else
        begin : g_rest
            assign d_src[k] = d_reg[k-1];
        end

        always_comb
        begin
            div_t        cur;
            logic [32:0] r33;
            cur = d_src[k];
            for (int j = 0; j < 2; j++)
            begin
                r33 = {cur.rem, cur.nq[DIV_W-1]};
                if (r33 >= {1'b0, cur.vt})
                begin
                    cur.rem = 32'(r33 - {1'b0, cur.vt});
                    cur.nq  = {cur.nq[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    cur.rem = r33[31:0];
                    cur.nq  = {cur.nq[DIV_W-2:0], 1'b0};
                end
            end
            d_next[k] = cur;
        end
    end

    // Partial products of h^2 * v for the inverse mode.
    always_comb
    begin
        m1_next.tag  = d_reg[DIV_STAGES-1].tag;
        m1_next.quot = d_reg[DIV_STAGES-1].nq;
        m1_next.tv2  = d_reg[DIV_STAGES-1].tv2;
        m1_next.pl   = 64'(d_reg[DIV_STAGES-1].h2[31:0]) * 64'(d_reg[DIV_STAGES-1].vt);
        m1_next.ph   = 64'(d_reg[DIV_STAGES-1].h2[63:32]) * 64'(d_reg[DIV_STAGES-1].vt);
    end

    // Combine the partial products and pick the term for the mode.
    always_comb
    begin
        logic [95:0] prod;
        prod         = {m1_reg.ph, 32'd0} + {32'd0, m1_reg.pl};
        m2_next.tag  = m1_reg.tag;
        m2_next.sel  = inverse_mode_reg ? {prod, 26'd0}
                                        : {{(SEL_W-DIV_W){1'b0}}, m1_reg.quot};
        m2_next.tv2  = m1_reg.tv2;
    end

    // Add t^2 and scale by four for the half-sample rounding test.
    always_comb
    begin
        logic [X_W-1:0] sum;
        sum          = {{(X_W-SEL_W){1'b0}}, m2_reg.sel}
                       + {{(X_W-64){1'b0}}, m2_reg.tv2};
        m3_next.tag  = m2_reg.tag;
        m3_next.x    = {sum[X_W-3:0], 2'b00};
        m3_next.root = '0;
        m3_next.rem  = '0;
    end

    // Digit-by-digit integer square root, one root bit per stage.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        if (k == 0)
        begin : g_first
            assign sq_src[k] = m3_reg;
        end
        else
        begin : g_rest
            assign sq_src[k] = sq_reg[k-1];
        end

        always_comb
        begin
            sq_t               cur;
            logic [ROOT_W+2:0] rem2;
            logic [ROOT_W+2:0] trial;
            cur   = sq_src[k];
            rem2  = {cur.rem[ROOT_W:0], cur.x[X_W-1:X_W-2]};
            trial = {1'b0, cur.root, 2'b01};
            if (rem2 >= trial)
            begin
                cur.rem  = rem2 - trial;
                cur.root = {cur.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                cur.rem  = rem2;
                cur.root = {cur.root[ROOT_W-2:0], 1'b0};
            end
            cur.x = {cur.x[X_W-3:0], 2'b00};
            sq_next[k] = cur;
        end
    end

    // Root over dt: check for saturation first, then divide the low bits.
    always_comb
    begin
        logic [ROOT_W-1:0] s;
        s            = sq_reg[ROOT_W-1].root;
        qp_next.tag  = sq_reg[ROOT_W-1].tag;
        qp_next.ovf  = s[ROOT_W-1:Q_W] >= {{(ROOT_W-Q_W-32){1'b0}}, sample_interval_reg};
        qp_next.rem  = s[Q_W+31:Q_W];
        qp_next.s_lo = s[Q_W-1:0];
        qp_next.q    = '0;
    end

    for (genvar k = 0; k < Q_STAGES; k++)
    begin : g_qdiv
        if (k == 0)
        begin : g_first
            assign q_src[k] = qp_reg;
        end
        else
        begin : g_rest
            assign q_src[k] = q_reg[k-1];
        end

        always_comb
        begin
            qd_t         cur;
            logic [32:0] r33;
            cur = q_src[k];
            for (int j = 0; j < 2; j++)
            begin
                r33      = {cur.rem, cur.s_lo[Q_W-1]};
                cur.s_lo = {cur.s_lo[Q_W-2:0], 1'b0};
                if (r33 >= {1'b0, sample_interval_reg})
                begin
                    cur.rem = 32'(r33 - {1'b0, sample_interval_reg});
                    cur.q   = {cur.q[Q_W-2:0], 1'b1};
                end
                else
                begin
                    cur.rem = r33[31:0];
                    cur.q   = {cur.q[Q_W-2:0], 1'b0};
                end
            end
            q_next[k] = cur;
        end
    end

    // Nearest sample is (q + 1) / 2, capped at nt; a cap at nt marks the
    // pair as out of range. A zero dt saturates through the overflow check.
    always_comb
    begin
        qd_t         cur;
        logic [Q_W:0]   q1;
        logic [Q_W-1:0] n;
        logic [Q_W-1:0] nt_w;
        logic [Q_W-1:0] itime;
        logic           ok;
        cur   = q_reg[Q_STAGES-1];
        q1    = {1'b0, cur.q} + 15'd1;
        n     = q1[Q_W:1];
        nt_w  = {1'b0, nt};
        itime = (cur.ovf || (n > nt_w)) ? nt_w : n;
        ok    = cur.tag.pre_ok && (itime < nt_w);
        out_next.entry_slot    = cur.tag.entry_slot;
        out_next.data_address  = ok ? (cur.tag.data_base + 20'(itime)) : 20'd0;
        out_next.model_address = ok ? cur.tag.model_address : 20'd0;
        out_next.pair_valid    = ok;
        out_next.divide_fault  = cur.tag.divide_fault;
    end

    // Payload registers, all held together while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg.sample_index  <= points.sample_index;
            s0_reg.offset_index  <= points.offset_index;
            s0_reg.curve_index   <= points.curve_index;
            s0_reg.time_value    <= points.time_value;
            s0_reg.offset_value  <= points.offset_value;
            s0_reg.velocity_term <= points.velocity_term;
            p1_reg  <= p1_next;
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            m3_reg  <= m3_next;
            qp_reg  <= qp_next;
            out_reg <= out_next;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                d_reg[k] <= d_next[k];
            end
            for (int k = 0; k < ROOT_W; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k < Q_STAGES; k++)
            begin
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign pairs.entry_slot    = out_reg.entry_slot;
    assign pairs.data_address  = out_reg.data_address;
    assign pairs.model_address = out_reg.model_address;
    assign pairs.pair_valid    = out_reg.pair_valid;
    assign pairs.divide_fault  = out_reg.divide_fault;

endmodule

>>> test/hmi_pair_checker.sv
// Checker that predicts each index pair from the observed grid points and compares it.
`timescale 1ns / 1ps

module hmi_pair_checker
    import hmi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    hmi_point_if                   points,
    hmi_pair_if                    pairs,
    output int                     mismatches,
    output int                     pending
);

    localparam int unsigned NT_LIMIT = 4096;
    localparam int unsigned NQ_LIMIT = 256;
    localparam int unsigned OFF_LIMIT = 256;

    logic [31:0] dt_reg;
    logic [11:0] start_reg;
    logic [12:0] nt_reg;
    logic [8:0]  nq_reg;
    logic        inverse_reg;

    pair_t expected_pairs[$];

    // Nearest sample is the largest n with (2n-1)^2*dt^2 <= 4*T^2.
    function automatic pair_t moveout_pair(point_t p);
        logic [127:0]       h2w;
        logic [127:0]       t2;
        logic [127:0]       four_t2;
        logic [127:0]       sq;
        logic [63:0]        hmag;
        logic [63:0]        a;
        logic [31:0]        h;
        longint unsigned    slot;
        int unsigned        nt;
        int unsigned        nq;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        logic               fault;
        logic               ok;
        pair_t              r;
        nt = (32'(nt_reg) > NT_LIMIT) ? NT_LIMIT : 32'(nt_reg);
        nq = (32'(nq_reg) > NQ_LIMIT) ? NQ_LIMIT : 32'(nq_reg);
        h = p.offset_value;
        hmag = h[31] ? {32'b0, -h} : {32'b0, h};
        h2w = 128'(hmag) * 128'(hmag);
        fault = !inverse_reg && (p.velocity_term == 32'd0);
        ok = !fault && p.sample_index >= start_reg && p.sample_index < nt &&
             p.curve_index < nq && p.offset_index < OFF_LIMIT;
        r = '0;
        slot = longint'(p.offset_index) * nq * nt + longint'(p.curve_index) * nt +
               longint'(p.sample_index);
        r.entry_slot = slot[27:0];
        if (ok)
        begin
            if (inverse_reg)
                t2 = (h2w * {96'b0, p.velocity_term}) << 26;
            else
                t2 = (h2w << 42) / {96'b0, p.velocity_term};
            t2 = t2 + {96'b0, p.time_value} * {96'b0, p.time_value};
            four_t2 = t2 << 2;
            lo = 0;
            hi = nt;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                a = (64'(2 * mid) - 64'd1) * {32'b0, dt_reg};
                sq = {64'b0, a} * {64'b0, a};
                if (sq <= four_t2)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            if (lo >= nt)
                ok = 1'b0;
            else
            begin
                slot = longint'(p.offset_index) * nt + lo;
                r.data_address = slot[19:0];
                slot = longint'(p.curve_index) * nt + p.sample_index;
                r.model_address = slot[19:0];
            end
        end
        r.pair_valid = ok;
        r.divide_fault = fault;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pair_t  want;
        point_t pt;
        if (!rst_n)
        begin
            dt_reg      <= SAMPLE_INTERVAL_RESET;
            start_reg   <= START_SAMPLE_RESET;
            nt_reg      <= SAMPLES_IN_USE_RESET;
            nq_reg      <= CURVES_IN_USE_RESET;
            inverse_reg <= 1'b0;
            expected_pairs.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (pairs.valid && pairs.ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected pair transaction slot=%h", $time,
                             pairs.entry_slot);
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (want.entry_slot !== pairs.entry_slot)
                    begin
                        mismatches++;
                        $display("%0t: entry_slot expected %h actual %h", $time,
                                 want.entry_slot, pairs.entry_slot);
                    end
                    if (want.data_address !== pairs.data_address)
                    begin
                        mismatches++;
                        $display("%0t: data_address expected %h actual %h", $time,
                                 want.data_address, pairs.data_address);
                    end
                    if (want.model_address !== pairs.model_address)
                    begin
                        mismatches++;
                        $display("%0t: model_address expected %h actual %h", $time,
                                 want.model_address, pairs.model_address);
                    end
                    if (want.pair_valid !== pairs.pair_valid)
                    begin
                        mismatches++;
                        $display("%0t: pair_valid expected %b actual %b", $time,
                                 want.pair_valid, pairs.pair_valid);
                    end
                    if (want.divide_fault !== pairs.divide_fault)
                    begin
                        mismatches++;
                        $display("%0t: divide_fault expected %b actual %b", $time,
                                 want.divide_fault, pairs.divide_fault);
                    end
                end
            end
            if (points.valid && points.ready)
            begin
                pt.sample_index  = points.sample_index;
                pt.offset_index  = points.offset_index;
                pt.curve_index   = points.curve_index;
                pt.time_value    = points.time_value;
                pt.offset_value  = points.offset_value;
                pt.velocity_term = points.velocity_term;
                expected_pairs.push_back(moveout_pair(pt));
            end
            pending = expected_pairs.size();
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SAMPLE_INTERVAL: dt_reg      <= cfg_data;
                    CFG_START_SAMPLE:    start_reg   <= cfg_data[11:0];
                    CFG_SAMPLES_IN_USE:  nt_reg      <= cfg_data[12:0];
                    CFG_CURVES_IN_USE:   nq_reg      <= cfg_data[8:0];
                    CFG_INVERSE_MODE:    inverse_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> test/hyperbolic_moveout_index_top_tb.sv
// Testbench top that drives grid points and configurations and gives the verdict.
`timescale 1ns / 1ps

module hyperbolic_moveout_index_top_tb;
    import hmi_pkg::*;

    // The drain pause is longer than the pipeline is deep, which leaves some margin.
    localparam int DRAIN_CYCLES = 140;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 7;
    localparam int RANDOM_ITEMS = 90;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     pending;
    int                     cycles;
    int                     sender_idle_pct;
    int                     receiver_idle_pct;

    // The configuration currently loaded, kept here to shape the stimulus.
    logic [31:0] cur_dt;
    logic [11:0] cur_start;
    logic [12:0] cur_nt;
    logic [8:0]  cur_nq;
    logic        cur_inverse;

    hmi_point_if points ();
    hmi_pair_if  pairs ();

    hyperbolic_moveout_index_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (points),
        .pairs     (pairs)
    );

    hmi_pair_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .points     (points),
        .pairs      (pairs),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // The receiver decides at every falling edge whether it takes a transaction.
    always @(negedge clk)
    begin
        pairs.ready = ($urandom_range(99) >= receiver_idle_pct);
    end

    // A cycle counter guards against a hung pipeline.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drives one grid point; called at a falling edge and returns at a falling edge.
    task automatic send_point(input point_t p);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            points.valid = 1'b0;
            @(negedge clk);
        end
        points.valid         = 1'b1;
        points.sample_index  = p.sample_index;
        points.offset_index  = p.offset_index;
        points.curve_index   = p.curve_index;
        points.time_value    = p.time_value;
        points.offset_value  = p.offset_value;
        points.velocity_term = p.velocity_term;
        @(posedge clk);
        while (!points.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every expected pair has been seen, then lets the pipeline settle.
    task automatic drain_pipeline();
        points.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic load_config(input logic [31:0] dt, input logic [11:0] start,
                               input logic [12:0] nt, input logic [8:0] nq,
                               input logic inverse);
        write_reg(CFG_SAMPLE_INTERVAL, dt);
        write_reg(CFG_START_SAMPLE, {20'b0, start});
        write_reg(CFG_SAMPLES_IN_USE, {19'b0, nt});
        write_reg(CFG_CURVES_IN_USE, {23'b0, nq});
        write_reg(CFG_INVERSE_MODE, {31'b0, inverse});
        cur_dt = dt;
        cur_start = start;
        cur_nt = nt;
        cur_nq = nq;
        cur_inverse = inverse;
    endtask

    // A value whose magnitude is spread over all scales.
    function automatic logic [31:0] spread_value();
        return $urandom >> $urandom_range(31, 0);
    endfunction

    // Well-formed points mostly land inside the trace so the root and the final
    // divide see realistic operands; the rest is unconstrained noise.
    function automatic point_t random_point();
        point_t          p;
        longint unsigned span;
        int unsigned     nt_eff;
        int unsigned     nq_eff;
        nt_eff = (cur_nt == 0) ? 1 : ((cur_nt > 4096) ? 4096 : 32'(cur_nt));
        nq_eff = (cur_nq == 0) ? 1 : ((cur_nq > 256) ? 256 : 32'(cur_nq));
        if ($urandom_range(99) < 20)
        begin
            p.sample_index  = 12'($urandom);
            p.offset_index  = 8'($urandom);
            p.curve_index   = 8'($urandom);
            p.time_value    = $urandom;
            p.offset_value  = $urandom;
            p.velocity_term = $urandom;
        end
        else
        begin
            span = longint'(cur_dt) * nt_eff;
            if (span > 64'hFFFF_FFFF)
                span = 64'hFFFF_FFFF;
            p.sample_index  = 12'($urandom_range(nt_eff - 1, 0));
            p.offset_index  = 8'($urandom);
            p.curve_index   = 8'($urandom_range(nq_eff - 1, 0));
            p.time_value    = $urandom_range(span[31:0], 0);
            p.offset_value  = spread_value();
            if ($urandom_range(1))
                p.offset_value = -p.offset_value;
            p.velocity_term = cur_inverse ? spread_value() : ~spread_value();
        end
        return p;
    endfunction

    // Field extremes, a zero velocity term, the start boundary, the last
    // sample and times at and just below half a sample past zero.
    task automatic send_directed();
        point_t p;
        p = '0;
        send_point(p);
        p = '1;
        p.offset_value = 32'h7FFF_FFFF;
        send_point(p);
        p = '0;
        p.offset_value = 32'h8000_0000;
        send_point(p);
        p.offset_value = 32'h0000_0100;
        p.velocity_term = 32'd0;
        p.sample_index = cur_start;
        send_point(p);
        p.sample_index = (cur_start != 0) ? cur_start - 12'd1 : 12'd0;
        p.velocity_term = 32'd1;
        send_point(p);
        p = '0;
        p.sample_index = cur_nt[11:0] - 12'd1;
        p.time_value = cur_dt * 32'(cur_nt - 13'd1);
        p.velocity_term = 32'hFFFF_FFFF;
        send_point(p);
        p.sample_index = cur_start;
        p.time_value = cur_dt >> 1;
        send_point(p);
        p.time_value = (cur_dt >> 1) - 32'd1;
        send_point(p);
    endtask

    initial
    begin
        logic [31:0] dts[PHASES];
        logic [11:0] starts[PHASES];
        logic [12:0] nts[PHASES];
        logic [8:0]  nqs[PHASES];
        logic        invs[PHASES];
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        points.valid = 1'b0;
        points.sample_index = '0;
        points.offset_index = '0;
        points.curve_index = '0;
        points.time_value = '0;
        points.offset_value = '0;
        points.velocity_term = '0;
        pairs.ready = 1'b0;
        sender_idle_pct = 24;
        receiver_idle_pct = 59;
        cur_dt = SAMPLE_INTERVAL_RESET;
        cur_start = START_SAMPLE_RESET;
        cur_nt = SAMPLES_IN_USE_RESET;
        cur_nq = CURVES_IN_USE_RESET;
        cur_inverse = 1'b0;

        // Settings run from the reset values through both register extremes.
        dts    = '{32'd67109, 32'h0010_0000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd4000000,
                   32'd50000};
        starts = '{12'd0, 12'd10, 12'd4095, 12'd0, 12'd0, 12'd5, 12'd0};
        nts    = '{13'd4096, 13'd100, 13'd8191, 13'd1, 13'd0, 13'd300, 13'd2048};
        nqs    = '{9'd256, 9'd16, 9'd511, 9'd1, 9'd0, 9'd40, 9'd200};
        invs   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The first phase runs on the reset values.
        send_directed();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 2)
            begin
                sender_idle_pct = 59;
                receiver_idle_pct = 24;
            end
            else if (ph == 5)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            if (ph != 0)
            begin
                drain_pipeline();
                load_config(dts[ph], starts[ph], nts[ph], nqs[ph], invs[ph]);
                if (ph == 1)
                    send_directed();
            end
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                // Halfway through one phase the sender waits for the pipeline to empty.
                if (ph == 3 && i == RANDOM_ITEMS / 2)
                    drain_pipeline();
                send_point(random_point());
            end
        end

        drain_pipeline();
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hmi_pkg.sv
rtl/core/hmi_point_if.sv
rtl/core/hmi_pair_if.sv
rtl/core/hyperbolic_moveout_index_top.sv
test/hmi_pair_checker.sv
test/hyperbolic_moveout_index_top_tb.sv
